// ===== rtl/core/tlge_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlge_pkg
// shared widths, operation codes, register indexes and size helpers for the
// toroidal life grid engine
// ----------------------------------------------------------------------------
package tlge_pkg;

    // built grid size
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;

    localparam int COL_AW  = $clog2(MAX_COLS);
    localparam int ROW_AW  = $clog2(MAX_ROWS);
    localparam int COLS_CW = $clog2(MAX_COLS + 1);
    localparam int ROWS_CW = $clog2(MAX_ROWS + 1);

    // payload field widths
    localparam int OP_W    = 3;
    localparam int COORD_W = 6;
    localparam int CNT_W   = 4;

    // configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     GRID_WIDTH_RST  = 7'd64;
    localparam logic [CFG_W-1:0]     GRID_HEIGHT_RST = 7'd64;

    // operation codes
    localparam logic [OP_W-1:0] OP_READ   = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
    localparam logic [OP_W-1:0] OP_TOGGLE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_STEP   = 3'd4;

    // b3/s23 neighbor counts
    localparam logic [CNT_W-1:0] SURVIVE_CNT = 4'd2;
    localparam logic [CNT_W-1:0] BIRTH_CNT   = 4'd3;

    // zero acts as one, oversize clamps to the built size
    function automatic logic [COLS_CW-1:0] eff_cols(input logic [CFG_W-1:0] v);
        logic [COLS_CW-1:0] r;
        if (v == '0)
            r = COLS_CW'(1);
        else if (int'(v) > MAX_COLS)
            r = COLS_CW'(MAX_COLS);
        else
            r = COLS_CW'(v);
        return r;
    endfunction

    function automatic logic [ROWS_CW-1:0] eff_rows(input logic [CFG_W-1:0] v);
        logic [ROWS_CW-1:0] r;
        if (v == '0)
            r = ROWS_CW'(1);
        else if (int'(v) > MAX_ROWS)
            r = ROWS_CW'(MAX_ROWS);
        else
            r = ROWS_CW'(v);
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tlge_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlge_req_if
// request channel: one grid operation per transaction
// ----------------------------------------------------------------------------
interface tlge_req_if
    import tlge_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               alive;

    modport source (output valid, output operation, output col, output row,
                    output alive, input ready);
    modport sink   (input valid, input operation, input col, input row,
                    input alive, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tlge_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlge_rsp_if
// response channel: one result per request
// ----------------------------------------------------------------------------
interface tlge_rsp_if;
    logic valid;
    logic ready;
    logic cell_value;
    logic bad_coord;

    modport source (output valid, output cell_value, output bad_coord, input ready);
    modport sink   (input valid, input cell_value, input bad_coord, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tlge_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlge_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tlge_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/tlge_row_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlge_row_calc
// next generation of one row from a three-row window, columns wrap at width
// ----------------------------------------------------------------------------
module tlge_row_calc
    import tlge_pkg::*;
(
    input  wire logic [MAX_COLS-1:0] up_row,
    input  wire logic [MAX_COLS-1:0] mid_row,
    input  wire logic [MAX_COLS-1:0] down_row,
    input  wire logic [COLS_CW-1:0]  width,
    output logic      [MAX_COLS-1:0] new_row
);
    logic [COL_AW-1:0] last_col;

    assign last_col = COL_AW'(width - COLS_CW'(1));

    always_comb
    begin
        logic [COL_AW-1:0] li;
        logic [COL_AW-1:0] ri;
        logic [CNT_W-1:0]  n;
        li = '0;
        ri = '0;
        n  = '0;
        for (int x = 0; x < MAX_COLS; x++)
        begin
            li = (x == 0) ? last_col : COL_AW'(x - 1);
            ri = (COL_AW'(x) == last_col) ? '0 : COL_AW'(x + 1);
            // small widths land on the same column more than once, each counts
            n = CNT_W'(up_row[li]) + CNT_W'(up_row[COL_AW'(x)]) + CNT_W'(up_row[ri])
              + CNT_W'(mid_row[li]) + CNT_W'(mid_row[ri])
              + CNT_W'(down_row[li]) + CNT_W'(down_row[COL_AW'(x)])
              + CNT_W'(down_row[ri]);
            if (x < int'(width))
                new_row[x] = mid_row[x] ? (n == SURVIVE_CNT || n == BIRTH_CNT)
                                        : (n == BIRTH_CNT);
            else
                new_row[x] = mid_row[x];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/toroidal_life_grid_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// toroidal_life_grid_engine_unit
// b3/s23 life grid on a torus, rows kept in one ram, row-sweep generation step
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | req.valid/ready   | operation, col, row, alive
//  rsp     | out       | rsp.valid/ready   | cell_value, bad_coord
//  cfg     | in        | cfg_we            | cfg_index, cfg_data
//
//  read/write/toggle: ram read, then modify and write back, then the result is loaded
//  clear, unused codes and bad coordinates skip the ram; step: last row, row 0 and row 1
//  are preloaded, then one row per cycle through the ram with a three-row window in registers
//  the next request is taken in the cycle after the result is loaded
//  reset clears the per-row valid flags at once, no clearing pass
//  a new request is taken while a result waits in the output register; a
//  finished operation holds until the output register is free
// ----------------------------------------------------------------------------
module toroidal_life_grid_engine_unit
    import tlge_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    tlge_req_if.sink                  req,
    tlge_rsp_if.source                rsp,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_PRE1  = 3'd3;
    localparam logic [2:0] S_PRE2  = 3'd4;
    localparam logic [2:0] S_SWEEP = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [OP_W-1:0]     op_reg;
    logic [COORD_W-1:0]  col_reg, row_reg;
    logic                alive_reg;
    logic [ROW_AW-1:0]   y_reg;
    logic [MAX_COLS-1:0] prev_reg, cur_reg, first_reg;
    logic [MAX_ROWS-1:0] row_valid_reg;
    logic                rvalid_reg;
    logic                res_value_reg, res_bad_reg;
    logic                out_valid_reg, out_value_reg, out_bad_reg;
    logic [CFG_W-1:0]    width_reg, height_reg;

    logic [COLS_CW-1:0]  w_eff;
    logic [ROWS_CW-1:0]  h_eff;
    logic                cell_op, bad, at_last, cell_old, cell_new, out_load;
    logic [MAX_COLS-1:0] ram_rdata, rd_row, down_row, mod_row, calc_row;
    logic                ram_we, ram_re;
    logic [ROW_AW-1:0]   ram_waddr, ram_raddr;
    logic [MAX_COLS-1:0] ram_wdata;

    assign w_eff   = eff_cols(width_reg);
    assign h_eff   = eff_rows(height_reg);
    assign cell_op = (op_reg == OP_READ) || (op_reg == OP_WRITE) || (op_reg == OP_TOGGLE);
    assign bad     = (int'(col_reg) >= int'(w_eff)) || (int'(row_reg) >= int'(h_eff));
    // rows never written since reset or clear read as dead
    assign rd_row   = ram_rdata & {MAX_COLS{rvalid_reg}};
    assign at_last  = (int'(y_reg) == int'(h_eff) - 1);
    // the row below the last one wraps to row 0, already overwritten in the ram
    assign down_row = at_last ? first_reg : rd_row;
    assign cell_old = rd_row[COL_AW'(col_reg)];

    always_comb
    begin
        case (op_reg)
            OP_WRITE:  cell_new = alive_reg;
            OP_TOGGLE: cell_new = ~cell_old;
            default:   cell_new = cell_old;
        endcase
        mod_row = rd_row;
        mod_row[COL_AW'(col_reg)] = cell_new;
    end

    tlge_row_calc u_row_calc (
        .up_row   (prev_reg),
        .mid_row  (cur_reg),
        .down_row (down_row),
        .width    (w_eff),
        .new_row  (calc_row)
    );

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = mod_row;
        case (state_reg)
            S_DISP:
            begin
                if (cell_op && !bad)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ROW_AW'(row_reg);
                end
                else if (op_reg == OP_STEP)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ROW_AW'(h_eff - ROWS_CW'(1));
                end
            end
            S_PRE1:
            begin
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            S_PRE2:
            begin
                ram_re    = 1'b1;
                ram_raddr = ROW_AW'(1);
            end
            S_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = y_reg;
                ram_wdata = calc_row;
                if (int'(y_reg) + 2 < int'(h_eff))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = y_reg + ROW_AW'(2);
                end
            end
            S_MOD:
            begin
                if (op_reg == OP_WRITE || op_reg == OP_TOGGLE)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ROW_AW'(row_reg);
                end
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    tlge_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                    state_next = S_DISP;
            end
            S_DISP:
            begin
                if (cell_op && !bad)
                    state_next = S_MOD;
                else if (op_reg == OP_STEP)
                    state_next = S_PRE1;
                else
                    state_next = S_DONE;
            end
            S_MOD:   state_next = S_DONE;
            S_PRE1:  state_next = S_PRE2;
            S_PRE2:  state_next = S_SWEEP;
            S_SWEEP:
            begin
                if (at_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.cell_value = out_value_reg;
    assign rsp.bad_coord  = out_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= 1'b0;
            out_bad_reg   <= 1'b0;
            width_reg     <= GRID_WIDTH_RST;
            height_reg    <= GRID_HEIGHT_RST;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= row_valid_reg[ram_raddr];

            if (cfg_we)
            begin
                if (cfg_index == REG_GRID_WIDTH)
                    width_reg <= cfg_data;
                else if (cfg_index == REG_GRID_HEIGHT)
                    height_reg <= cfg_data;
            end

            if (ram_we)
                row_valid_reg[ram_waddr] <= 1'b1;
            if (state_reg == S_DISP && op_reg == OP_CLEAR)
                row_valid_reg <= '0;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_value_reg <= res_value_reg;
                out_bad_reg   <= res_bad_reg;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_reg    <= req.operation;
                    col_reg   <= req.col;
                    row_reg   <= req.row;
                    alive_reg <= req.alive;
                end
            end
            S_DISP:
            begin
                res_value_reg <= 1'b0;
                res_bad_reg   <= cell_op && bad;
            end
            S_MOD:
            begin
                res_value_reg <= cell_new;
            end
            S_PRE1:
            begin
                prev_reg <= rd_row;
            end
            S_PRE2:
            begin
                cur_reg   <= rd_row;
                first_reg <= rd_row;
                y_reg     <= '0;
            end
            S_SWEEP:
            begin
                prev_reg <= cur_reg;
                cur_reg  <= down_row;
                y_reg    <= y_reg + ROW_AW'(1);
            end
            default:
            begin
                y_reg <= y_reg;
            end
        endcase
    end

    // the sweep never writes the row it is fetching
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("ram write and read hit the same row");

    a_clear_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DISP && op_reg == OP_CLEAR) |=> (row_valid_reg == '0))
        else $error("clear left a row valid");

    a_bad_is_dead: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |-> !out_value_reg)
        else $error("bad coordinate result carries a live cell");

    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (int'(y_reg) < int'(h_eff)))
        else $error("sweep row beyond height in use");

endmodule
`default_nettype wire

// ===== tb/toroidal_life_grid_engine_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_life_grid_engine_unit_test
// drives cell reads, writes, toggles, clears and generation steps into the
// life grid engine under several grid sizes and handshake stall patterns, and
// checks every response against a cycle-free grid predictor kept in the bench
// ----------------------------------------------------------------------------
module toroidal_life_grid_engine_unit_test;
    import tlge_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 800_000;
    localparam int MAX_GAP      = 40;
    localparam int SETTLE       = MAX_ROWS + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [OP_W-1:0] OP_LAST_CODE = '1;

    typedef struct packed {
        logic cell_value;
        logic bad_coord;
    } cell_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    tlge_req_if req_ch ();
    tlge_rsp_if rsp_ch ();

    toroidal_life_grid_engine_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted grid and register copies
    logic [MAX_COLS-1:0] life_cells [MAX_ROWS];
    logic [CFG_W-1:0]    cols_reg;
    logic [CFG_W-1:0]    rows_reg;
    cell_result_t        expected_cells [$];

    int  error_count;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_rsp;

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver side: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cell_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_cells.size() == 0)
            begin
                error_count++;
                $display("%0t: transaction with nothing expected, cell_value %0b bad_coord %0b",
                         $time, rsp_ch.cell_value, rsp_ch.bad_coord);
            end
            else
            begin
                want = expected_cells.pop_front();
                if (rsp_ch.cell_value !== want.cell_value)
                begin
                    error_count++;
                    $display("%0t: cell_value expected %0b actual %0b",
                             $time, want.cell_value, rsp_ch.cell_value);
                end
                if (rsp_ch.bad_coord !== want.bad_coord)
                begin
                    error_count++;
                    $display("%0t: bad_coord expected %0b actual %0b",
                             $time, want.bad_coord, rsp_ch.bad_coord);
                end
            end
        end
    end

    // zero acts as one, anything past the built size clamps to it
    function automatic int size_in_use(input logic [CFG_W-1:0] raw, input int built);
        if (raw == '0)
            return 1;
        if (int'(raw) > built)
            return built;
        return int'(raw);
    endfunction

    task automatic advance_generation(input int w, input int h);
        logic [MAX_COLS-1:0] next_gen [MAX_ROWS];
        int n;
        int nx;
        int ny;
        next_gen = life_cells;
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                n = 0;
                // wrapped offsets may hit the same cell more than once on tiny grids
                for (int dy = 0; dy < 3; dy++)
                begin
                    for (int dx = 0; dx < 3; dx++)
                    begin
                        if (dx == 1 && dy == 1)
                            continue;
                        nx = (x + w - 1 + dx) % w;
                        ny = (y + h - 1 + dy) % h;
                        n += life_cells[ny][nx];
                    end
                end
                if (life_cells[y][x])
                    next_gen[y][x] = (n == int'(SURVIVE_CNT)) || (n == int'(BIRTH_CNT));
                else
                    next_gen[y][x] = (n == int'(BIRTH_CNT));
            end
        end
        life_cells = next_gen;
    endtask

    task automatic apply_grid_op(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] col,
                                 input logic [COORD_W-1:0] row, input logic alive);
        cell_result_t res;
        int w;
        int h;
        w = size_in_use(cols_reg, MAX_COLS);
        h = size_in_use(rows_reg, MAX_ROWS);
        res = '0;
        if (op == OP_READ || op == OP_WRITE || op == OP_TOGGLE)
        begin
            if (int'(col) >= w || int'(row) >= h)
                res.bad_coord = 1'b1;
            else
            begin
                if (op == OP_WRITE)
                    life_cells[row][col] = alive;
                else if (op == OP_TOGGLE)
                    life_cells[row][col] = ~life_cells[row][col];
                res.cell_value = life_cells[row][col];
            end
        end
        else if (op == OP_CLEAR)
        begin
            for (int y = 0; y < MAX_ROWS; y++)
                life_cells[y] = '0;
        end
        else if (op == OP_STEP)
            advance_generation(w, h);
        expected_cells.push_back(res);
    endtask

    // valid is left high after the transaction so back-to-back items need no extra edge
    task automatic send_grid_op(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] col,
                                input logic [COORD_W-1:0] row, input logic alive);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge clk);
        repeat (gap)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.col       <= col;
        req_ch.row       <= row;
        req_ch.alive     <= alive;
        do
            @(posedge clk);
        while (!req_ch.ready);
        apply_grid_op(op, col, row, alive);
    endtask

    task automatic send_random_op();
        int w;
        int h;
        int pick;
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               alive;
        w     = size_in_use(cols_reg, MAX_COLS);
        h     = size_in_use(rows_reg, MAX_ROWS);
        pick  = $urandom_range(99);
        col   = COORD_W'($urandom_range(w - 1));
        row   = COORD_W'($urandom_range(h - 1));
        alive = ($urandom_range(99) < 45);
        if (pick < 33)
            op = OP_WRITE;
        else if (pick < 58)
            op = OP_READ;
        else if (pick < 69)
            op = OP_TOGGLE;
        else if (pick < 81)
            op = OP_STEP;
        else if (pick < 83)
            op = OP_CLEAR;
        else if (pick < 86)
            op = OP_W'($urandom_range(OP_LAST_CODE, OP_STEP + 1));
        else if (pick < 96)
        begin
            // coordinate outside the area in use, when that area is smaller than the built grid
            op = OP_W'($urandom_range(OP_TOGGLE, OP_READ));
            if (w < MAX_COLS && (h == MAX_ROWS || $urandom_range(1)))
            begin
                col = COORD_W'($urandom_range(MAX_COLS - 1, w));
                row = COORD_W'($urandom_range(MAX_ROWS - 1));
            end
            else if (h < MAX_ROWS)
            begin
                row = COORD_W'($urandom_range(MAX_ROWS - 1, h));
                col = COORD_W'($urandom_range(MAX_COLS - 1));
            end
        end
        else
        begin
            // raw noise over the full field ranges
            op    = OP_W'($urandom_range(OP_LAST_CODE));
            col   = COORD_W'($urandom_range(MAX_COLS - 1));
            row   = COORD_W'($urandom_range(MAX_ROWS - 1));
        end
        send_grid_op(op, col, row, alive);
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_grid_size(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
        wait_until_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GRID_WIDTH;
        cfg_data  <= cols;
        @(negedge clk);
        cfg_index <= REG_GRID_HEIGHT;
        cfg_data  <= rows;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cols_reg = cols;
        rows_reg = rows;
    endtask

    task automatic test_directed_ops();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_grid_op(OP_READ, 0, 0, 1'b0);
        send_grid_op(OP_WRITE, 63, 63, 1'b1);
        send_grid_op(OP_READ, 63, 63, 1'b0);
        send_grid_op(OP_WRITE, 0, 0, 1'b1);
        send_grid_op(OP_TOGGLE, 0, 0, 1'b0);
        send_grid_op(OP_TOGGLE, 0, 0, 1'b1);
        send_grid_op(OP_WRITE, 5, 7, 1'b0);
        for (int c = OP_STEP + 1; c <= OP_LAST_CODE; c++)
            send_grid_op(OP_W'(c), 63, 63, 1'b1);
        send_grid_op(OP_CLEAR, 0, 0, 1'b0);
        send_grid_op(OP_READ, 63, 63, 1'b0);
        // blinker away from the seams
        send_grid_op(OP_WRITE, 10, 10, 1'b1);
        send_grid_op(OP_WRITE, 11, 10, 1'b1);
        send_grid_op(OP_WRITE, 12, 10, 1'b1);
        send_grid_op(OP_STEP, 0, 0, 1'b0);
        send_grid_op(OP_READ, 11, 9, 1'b0);
        send_grid_op(OP_READ, 11, 11, 1'b0);
        send_grid_op(OP_READ, 10, 10, 1'b0);
        // two live cells across the left/right seam on row 0, read back across the top/bottom seam
        send_grid_op(OP_WRITE, 63, 0, 1'b1);
        send_grid_op(OP_WRITE, 1, 0, 1'b1);
        send_grid_op(OP_STEP, 0, 0, 1'b0);
        send_grid_op(OP_READ, 0, 63, 1'b0);
        send_grid_op(OP_READ, 0, 1, 1'b0);
    endtask

    task automatic test_size_extremes();
        send_grid_op(OP_WRITE, 40, 40, 1'b1);
        write_grid_size('0, '0);
        send_grid_op(OP_WRITE, 0, 0, 1'b1);
        send_grid_op(OP_READ, 1, 0, 1'b0);
        send_grid_op(OP_READ, 0, 1, 1'b0);
        send_grid_op(OP_STEP, 0, 0, 1'b0);
        send_grid_op(OP_READ, 0, 0, 1'b0);
        send_grid_op(OP_CLEAR, 0, 0, 1'b0);
        write_grid_size(7'd2, 7'd1);
        send_grid_op(OP_WRITE, 0, 0, 1'b1);
        send_grid_op(OP_WRITE, 1, 0, 1'b1);
        send_grid_op(OP_STEP, 0, 0, 1'b0);
        send_grid_op(OP_READ, 0, 0, 1'b0);
        send_grid_op(OP_READ, 1, 0, 1'b0);
        // oversize clamps to the built grid; clear must have reached (40,40)
        write_grid_size('1, '1);
        send_grid_op(OP_READ, 40, 40, 1'b0);
        send_grid_op(OP_WRITE, 63, 63, 1'b1);
        send_grid_op(OP_READ, 63, 63, 1'b0);
    endtask

    task automatic test_output_backpressure();
        write_grid_size(7'd8, 7'd8);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                @(posedge clk);
                hold_rsp = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            repeat (30) send_random_op();
        join
    endtask

    task automatic test_random_phase(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows,
                                     input int items, input int idle_pct, input int stall_pct);
        write_grid_size(cols, rows);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items) send_random_op();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_GRID_WIDTH;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_READ;
        req_ch.col       = '0;
        req_ch.row       = '0;
        req_ch.alive     = 1'b0;
        rsp_ch.ready     = 1'b0;
        hold_rsp         = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        error_count      = 0;
        cycle_count      = 0;
        cols_reg         = GRID_WIDTH_RST;
        rows_reg         = GRID_HEIGHT_RST;
        for (int y = 0; y < MAX_ROWS; y++)
            life_cells[y] = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_ops();
        test_size_extremes();
        test_output_backpressure();
        test_random_phase(7'd12, 7'd10, 160, 0, 0);
        test_random_phase(7'd64, 7'd64, 130, 64, 0);
        test_random_phase(7'd7, 7'd5, 160, 0, 64);
        test_random_phase(7'd127, 7'd3, 140, 12, 12);
        test_random_phase(7'd2, 7'd1, 90, 0, 0);
        test_random_phase(7'd0, 7'd9, 80, 12, 12);
        test_random_phase(7'd3, 7'd2, 60, 64, 64);
        test_random_phase(7'd20, 7'd20, 60, 0, 0);

        wait_until_drained();
        if (error_count == 0 && expected_cells.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
